// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the masked SNR estimator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define MSNR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("masked_snr_estimator: assertion failed");
// Next-cycle implication.
`define MSNR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("masked_snr_estimator: assertion failed");
`else
`define MSNR_ASSERT_IMP(label, ante, cons)
`define MSNR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/msnr_pkg.sv =====
// Shared constants, types and status codes of the masked SNR estimator.
`default_nettype none
package msnr_pkg;

  localparam int COUNT_BITS_DEF  = 25;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;
  localparam int RES_BITS        = 24;
  localparam int DB_BITS         = 16;

  // 20*log10(2) in Q16
  localparam logic signed [19:0] DB_PER_OCTAVE = 20'sd394566;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SIGNAL = 2'd1,
    ST_FEW_NOISE = 2'd2,
    ST_NONPOS    = 2'd3
  } status_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

// ===== sv/msnr_queue.sv =====
// Small register queue of finished volume records between front and back.
`default_nettype none
module msnr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = msnr_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [WIDTH-1:0]     din,
  input  logic                 pop,
  output logic [WIDTH-1:0]     dout,
  output msnr_pkg::q_status_t  qstat
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign dout        = mem[rd_ptr];
  assign qstat.full  = (count == CW'(DEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/msnr_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the back end.
`default_nettype none
module msnr_div #(
  parameter int NW = 48,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);

  logic          active;
  logic [CW-1:0] cnt;
  logic [NW-1:0] shreg;
  logic [DW-1:0] rem;
  logic [DW-1:0] dreg;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem, shreg[NW-1]};
  assign ge    = (trial >= {1'b0, dreg});

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CW'(NW);
        shreg  <= num;
        dreg   <= den;
        rem    <= '0;
        quo    <= '0;
      end else if (active) begin
        rem   <= ge ? DW'(trial - {1'b0, dreg}) : trial[DW-1:0];
        quo   <= {quo[NW-2:0], ge};
        shreg <= {shreg[NW-2:0], 1'b0};
        cnt   <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/msnr_front.sv =====
// Front end: takes voxel words, accumulates per region, pushes a record on last.
`default_nettype none
module msnr_front #(
  parameter int SAMPLE_BITS = msnr_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = msnr_pkg::COUNT_BITS_DEF,
  parameter int RW          = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          is_signal,
  input  logic                          last,
  input  logic                          voxel_valid,
  output logic                          voxel_ready,
  input  msnr_pkg::q_status_t           qstat,
  output logic                          push,
  output logic [RW-1:0]                 rec
);
  localparam int SB  = SAMPLE_BITS;
  localparam int CB  = COUNT_BITS;
  localparam int SW  = SB + CB;
  localparam int QSW = 2 * SB + CB;

  logic signed [SW-1:0]   ssum, ssum_next;
  logic signed [SW-1:0]   nsum, nsum_next;
  logic [QSW-1:0]         sqsum, sqsum_next;
  logic [CB-1:0]          scnt, scnt_next;
  logic [CB-1:0]          ncnt, ncnt_next;
  logic signed [SW-1:0]   s_ext;
  logic signed [2*SB-1:0] s_wide;
  logic signed [2*SB-1:0] s_sq;
  logic                   accept;

  assign voxel_ready = !qstat.full;
  assign accept      = voxel_valid && voxel_ready;
  assign s_ext       = {{(SW - SB){sample[SB-1]}}, sample};
  assign s_wide      = {{SB{sample[SB-1]}}, sample};
  assign s_sq        = s_wide * s_wide;

  always_comb begin
    ssum_next  = ssum;
    nsum_next  = nsum;
    sqsum_next = sqsum;
    scnt_next  = scnt;
    ncnt_next  = ncnt;
    // drop voxels of a region whose count is saturated
    if (is_signal) begin
      if (!(&scnt)) begin
        ssum_next = ssum + s_ext;
        scnt_next = scnt + 1'b1;
      end
    end else if (!(&ncnt)) begin
      nsum_next  = nsum + s_ext;
      sqsum_next = sqsum + QSW'($unsigned(s_sq));
      ncnt_next  = ncnt + 1'b1;
    end
  end

  assign push = accept && last;
  assign rec  = {ssum_next, nsum_next, sqsum_next, scnt_next, ncnt_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      ssum  <= '0;
      nsum  <= '0;
      sqsum <= '0;
      scnt  <= '0;
      ncnt  <= '0;
    end else if (accept) begin
      if (last) begin
        ssum  <= '0;
        nsum  <= '0;
        sqsum <= '0;
        scnt  <= '0;
        ncnt  <= '0;
      end else begin
        ssum  <= ssum_next;
        nsum  <= nsum_next;
        sqsum <= sqsum_next;
        scnt  <= scnt_next;
        ncnt  <= ncnt_next;
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/msnr_back.sv =====
// Back end: sequencer that turns one volume record into the result word.
`default_nettype none
module msnr_back #(
  parameter int SAMPLE_BITS = msnr_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = msnr_pkg::COUNT_BITS_DEF,
  parameter int RW          = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  msnr_pkg::q_status_t qstat,
  input  logic [RW-1:0]       rec,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_ready,
  output logic [23:0]         signal_mean,
  output logic [23:0]         noise_mean,
  output logic [23:0]         noise_deviation,
  output logic [23:0]         ratio,
  output logic [15:0]         ratio_db,
  output msnr_pkg::status_t   status
);
  localparam int SB  = SAMPLE_BITS;
  localparam int CB  = COUNT_BITS;
  localparam int SW  = SB + CB;
  localparam int QSW = 2 * SB + CB;
  localparam int MW  = 2 * SB + 2 * CB;
  localparam int NW  = MW + 16;
  localparam int DW  = (2 * CB > 24) ? 2 * CB : 24;
  localparam int SQW = 2 * SB + 16;
  localparam int R   = SQW / 2;
  localparam int MCW = $clog2(SW);
  localparam int RCW = $clog2(R);

  typedef enum logic [4:0] {
    S_IDLE, S_SM_GO, S_SM_WAIT, S_NM_GO, S_NM_WAIT, S_MUL_A, S_MUL_B, S_MUL_C,
    S_DEV_WAIT, S_SQRT, S_SQRT_FIN, S_STATUS, S_RAT_WAIT, S_LOG_NORM,
    S_LOG_MUL, S_LOG_SQ, S_DB_MUL, S_DB_FIN, S_OUT
  } state_t;

  state_t state;

  logic signed [SW-1:0] ssum, nsum;
  logic [QSW-1:0]       sqsum;
  logic [CB-1:0]        scnt, ncnt;
  logic [SW-1:0]        smag, nmag;

  logic [MW-1:0]  mul_a, acc, acc_step, pa, pb, diff;
  logic [SW-1:0]  mul_b;
  logic [MCW-1:0] mcnt;

  logic          div_start, div_done;
  logic [NW-1:0] div_num, div_quo;
  logic [DW-1:0] div_den;

  logic [SQW-1:0] sq_q;
  logic [R-1:0]   root;
  logic [R+1:0]   srem;
  logic [R+3:0]   remn;
  logic [R+3:0]   trial;
  logic           sq_ge;
  logic [R:0]     rounded;
  logic [RCW-1:0] rcnt;

  logic [30:0]          mant;
  logic [4:0]           expo;
  logic [61:0]          sqp;
  logic [31:0]          xsq;
  logic [15:0]          frac;
  logic [3:0]           fidx;
  logic signed [6:0]    e_m8;
  logic signed [22:0]   lq;
  logic signed [42:0]   prod;
  logic signed [42:0]   prod_rnd;
  logic signed [18:0]   db_q;

  logic [23:0]          smean, nmean, dev, rat, smean_mag, rat_new;
  logic [15:0]          db;
  msnr_pkg::status_t    stat;

  function automatic logic [23:0] sat24(input logic neg, input logic [NW-1:0] mag);
    logic [NW-1:0] negm;
    negm = -mag;
    if (neg) begin
      return (mag > NW'(24'h800000)) ? 24'h800000 : negm[23:0];
    end
    return (mag > NW'(24'h7FFFFF)) ? 24'h7FFFFF : mag[23:0];
  endfunction

  msnr_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign pop       = (state == S_IDLE) && !qstat.empty;
  assign smag      = ssum[SW-1] ? SW'(-ssum) : SW'(ssum);
  assign nmag      = nsum[SW-1] ? SW'(-nsum) : SW'(nsum);
  assign acc_step  = mul_b[0] ? acc + mul_a : acc;
  assign diff      = (pa >= pb) ? pa - pb : '0;
  assign remn      = {srem, sq_q[SQW-1:SQW-2]};
  assign trial     = {2'b00, root, 2'b01};
  assign sq_ge     = (remn >= trial);
  assign rounded   = {1'b0, root} + (R+1)'(srem > (R+2)'(root));
  assign xsq       = sqp[61:30];
  assign e_m8      = $signed({2'b00, expo}) - 7'sd8;
  assign lq        = {e_m8, frac};
  assign prod_rnd  = prod + 43'sd8388608;
  assign db_q      = 19'(prod_rnd >>> 24);
  assign smean_mag = smean[23] ? -smean : smean;
  assign rat_new   = sat24(smean[23], div_quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      div_start    <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!qstat.empty) begin
            {ssum, nsum, sqsum, scnt, ncnt} <= rec;
            smean <= '0;
            nmean <= '0;
            dev   <= '0;
            rat   <= '0;
            db    <= '0;
            state <= S_SM_GO;
          end
        end
        S_SM_GO: begin
          if (scnt == '0) begin
            state <= S_NM_GO;
          end else begin
            div_num   <= NW'({smag, 8'h00}) + NW'(scnt >> 1);
            div_den   <= DW'(scnt);
            div_start <= 1'b1;
            state     <= S_SM_WAIT;
          end
        end
        S_SM_WAIT: begin
          if (div_done) begin
            smean <= sat24(ssum[SW-1], div_quo);
            state <= S_NM_GO;
          end
        end
        S_NM_GO: begin
          if (ncnt == '0) begin
            state <= S_STATUS;
          end else begin
            div_num   <= NW'({nmag, 8'h00}) + NW'(ncnt >> 1);
            div_den   <= DW'(ncnt);
            div_start <= 1'b1;
            state     <= S_NM_WAIT;
          end
        end
        S_NM_WAIT: begin
          if (div_done) begin
            nmean <= sat24(nsum[SW-1], div_quo);
            if (ncnt >= CB'(2)) begin
              // n * S2, one multiplier bit per cycle
              mul_a <= MW'(sqsum);
              mul_b <= SW'(ncnt);
              acc   <= '0;
              mcnt  <= MCW'(SW - 1);
              state <= S_MUL_A;
            end else begin
              state <= S_STATUS;
            end
          end
        end
        S_MUL_A, S_MUL_B, S_MUL_C: begin
          acc   <= acc_step;
          mul_a <= {mul_a[MW-2:0], 1'b0};
          mul_b <= {1'b0, mul_b[SW-1:1]};
          mcnt  <= mcnt - 1'b1;
          if (mcnt == '0) begin
            acc  <= '0;
            mcnt <= MCW'(SW - 1);
            if (state == S_MUL_A) begin
              pa    <= acc_step;
              mul_a <= MW'(nmag);
              mul_b <= nmag;
              state <= S_MUL_B;
            end else if (state == S_MUL_B) begin
              pb    <= acc_step;
              mul_a <= MW'(ncnt);
              mul_b <= SW'(ncnt - 1'b1);
              state <= S_MUL_C;
            end else begin
              div_num   <= {diff, 16'h0000};
              div_den   <= DW'(acc_step[2*CB-1:0]);
              div_start <= 1'b1;
              state     <= S_DEV_WAIT;
            end
          end
        end
        S_DEV_WAIT: begin
          if (div_done) begin
            sq_q  <= (|(div_quo >> SQW)) ? '1 : div_quo[SQW-1:0];
            root  <= '0;
            srem  <= '0;
            rcnt  <= RCW'(R - 1);
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          srem <= sq_ge ? (R+2)'(remn - trial) : remn[R+1:0];
          root <= {root[R-2:0], sq_ge};
          sq_q <= {sq_q[SQW-3:0], 2'b00};
          rcnt <= rcnt - 1'b1;
          if (rcnt == '0) begin
            state <= S_SQRT_FIN;
          end
        end
        S_SQRT_FIN: begin
          dev   <= (rounded > (R+1)'(24'hFFFFFF)) ? 24'hFFFFFF : 24'(rounded);
          state <= S_STATUS;
        end
        S_STATUS: begin
          if (scnt == '0) begin
            stat  <= msnr_pkg::ST_NO_SIGNAL;
            state <= S_OUT;
          end else if (ncnt < CB'(2)) begin
            stat  <= msnr_pkg::ST_FEW_NOISE;
            state <= S_OUT;
          end else if (dev == '0) begin
            stat  <= msnr_pkg::ST_NONPOS;
            state <= S_OUT;
          end else begin
            div_num   <= NW'({smean_mag, 8'h00}) + NW'(dev >> 1);
            div_den   <= DW'(dev);
            div_start <= 1'b1;
            state     <= S_RAT_WAIT;
          end
        end
        S_RAT_WAIT: begin
          if (div_done) begin
            rat <= rat_new;
            if (rat_new[23] || rat_new == '0) begin
              stat  <= msnr_pkg::ST_NONPOS;
              db    <= 16'h8000;
              state <= S_OUT;
            end else begin
              stat  <= msnr_pkg::ST_OK;
              mant  <= {rat_new[22:0], 8'h00};
              expo  <= 5'd22;
              state <= S_LOG_NORM;
            end
          end
        end
        S_LOG_NORM: begin
          if (mant[30]) begin
            frac  <= '0;
            fidx  <= 4'd15;
            state <= S_LOG_MUL;
          end else begin
            mant <= {mant[29:0], 1'b0};
            expo <= expo - 1'b1;
          end
        end
        S_LOG_MUL: begin
          sqp   <= 62'(mant) * 62'(mant);
          state <= S_LOG_SQ;
        end
        S_LOG_SQ: begin
          if (xsq[31]) begin
            mant       <= xsq[31:1];
            frac[fidx] <= 1'b1;
          end else begin
            mant <= xsq[30:0];
          end
          fidx  <= fidx - 1'b1;
          state <= (fidx == '0) ? S_DB_MUL : S_LOG_MUL;
        end
        S_DB_MUL: begin
          prod  <= 43'(lq) * 43'(msnr_pkg::DB_PER_OCTAVE);
          state <= S_DB_FIN;
        end
        S_DB_FIN: begin
          if (db_q > 19'sd32767) begin
            db <= 16'h7FFF;
          end else if (db_q < -19'sd32768) begin
            db <= 16'h8000;
          end else begin
            db <= db_q[15:0];
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!result_valid || result_ready) begin
            signal_mean     <= smean;
            noise_mean      <= nmean;
            noise_deviation <= dev;
            ratio           <= rat;
            ratio_db        <= db;
            status          <= stat;
            result_valid    <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/masked_snr_estimator.sv =====
// Top level of the masked SNR estimator: front end, record queue, back end.
// Usage:
//   Voxel words enter on voxel_valid/voxel_ready with sample, is_signal and
//   last. One word is taken per cycle; the front end only stalls when the
//   record queue between the halves is full.
//   The word with last set closes a volume: its sums and counts are pushed as
//   one record and the accumulators clear for the next volume.
//   The back end turns each record into one result word on
//   result_valid/result_ready: both means, noise deviation, ratio, ratio in
//   dB and status. It reuses one bit-serial divider for four divisions, a
//   shift-add multiplier for the three wide products, a two-bit-per-cycle
//   square root and a squaring loop for the log.
//   Volumes that end early in the status checks skip the later steps;
//   volumes that close faster than the back end turns out results fill the
//   queue and then hold voxel_ready low.
//   A held result waits in its output register while the back end starts on
//   the next record; a stalled receiver delays results and backs up the queue.
//   Reset clears accumulators, queue, sequencer and result_valid.
`default_nettype none
`include "assert_macros.svh"
module masked_snr_estimator #(
  parameter int COUNT_BITS  = msnr_pkg::COUNT_BITS_DEF,
  parameter int SAMPLE_BITS = msnr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          is_signal,
  input  logic                          last,
  input  logic                          voxel_valid,
  output logic                          voxel_ready,
  output logic signed [23:0]            signal_mean,
  output logic signed [23:0]            noise_mean,
  output logic [23:0]                   noise_deviation,
  output logic signed [23:0]            ratio,
  output logic signed [15:0]            ratio_db,
  output logic [1:0]                    status,
  output logic                          result_valid,
  input  logic                          result_ready
);
  localparam int SW  = SAMPLE_BITS + COUNT_BITS;
  localparam int QSW = 2 * SAMPLE_BITS + COUNT_BITS;
  localparam int RW  = 2 * SW + QSW + 2 * COUNT_BITS;

  msnr_pkg::q_status_t qstat;
  msnr_pkg::status_t   stat;
  logic                push;
  logic                pop;
  logic [RW-1:0]       rec_in;
  logic [RW-1:0]       rec_out;
  logic [23:0]         smean_w, nmean_w, ratio_w;
  logic [15:0]         db_w;
  logic                out_ok, out_nosig, out_few;
  logic                ratio_pos, nosig_zero;

  msnr_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .RW          (RW)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample),
    .is_signal   (is_signal),
    .last        (last),
    .voxel_valid (voxel_valid),
    .voxel_ready (voxel_ready),
    .qstat       (qstat),
    .push        (push),
    .rec         (rec_in)
  );

  // hold closed volumes until the back end is free
  msnr_queue #(
    .WIDTH (RW),
    .DEPTH (msnr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (rec_in),
    .pop   (pop),
    .dout  (rec_out),
    .qstat (qstat)
  );

  msnr_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .RW          (RW)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .qstat           (qstat),
    .rec             (rec_out),
    .pop             (pop),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .signal_mean     (smean_w),
    .noise_mean      (nmean_w),
    .noise_deviation (noise_deviation),
    .ratio           (ratio_w),
    .ratio_db        (db_w),
    .status          (stat)
  );

  assign signal_mean = $signed(smean_w);
  assign noise_mean  = $signed(nmean_w);
  assign ratio       = $signed(ratio_w);
  assign ratio_db    = $signed(db_w);
  assign status      = stat;

  assign out_ok     = result_valid && (stat == msnr_pkg::ST_OK);
  assign out_nosig  = result_valid && (stat == msnr_pkg::ST_NO_SIGNAL);
  assign out_few    = result_valid && (stat == msnr_pkg::ST_FEW_NOISE);
  assign ratio_pos  = !ratio_w[23] && (ratio_w != '0);
  assign nosig_zero = (smean_w == '0) && (ratio_w == '0) && (db_w == '0);

  // a closed volume always lands in the queue
  `MSNR_ASSERT_NEXT(a_push_lands, push, !qstat.empty)
  // a good status means a strictly positive ratio
  `MSNR_ASSERT_IMP(a_ok_ratio, out_ok, ratio_pos)
  // no signal voxels: signal mean, ratio and dB all zero
  `MSNR_ASSERT_IMP(a_no_signal, out_nosig, nosig_zero)
  // too few noise voxels: no deviation
  `MSNR_ASSERT_IMP(a_few_noise, out_few, noise_deviation == '0)
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the masked SNR estimator: directed table, then random volumes.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COUNT_MAX  = (1 << msnr_pkg::COUNT_BITS_DEF) - 1;
  localparam int          WATCH_MAX  = 20000;  // cycles with no word moving on either side
  localparam int          HOLD_LEN   = 3000;   // long receiver hold-off in the last phase
  localparam int          DRAIN_WAIT = 650;    // about the last-to-result latency

  typedef struct packed {
    logic signed [23:0] smean;
    logic signed [23:0] nmean;
    logic        [23:0] dev;
    logic signed [23:0] ratio;
    logic signed [15:0] db;
    msnr_pkg::status_t  st;
  } snr_result_t;

  typedef struct packed {
    logic signed [15:0] s;
    logic               sig;
    logic               lst;
    logic               typed;
    snr_result_t        want;
  } voxel_row_t;

  localparam snr_result_t NO_WANT =
    '{24'sd0, 24'sd0, 24'd0, 24'sd0, 16'sd0, msnr_pkg::ST_OK};

  logic               clk;
  logic               rst;
  logic signed [15:0] sample;
  logic               is_signal;
  logic               last;
  logic               voxel_valid;
  logic               voxel_ready;
  logic signed [23:0] signal_mean;
  logic signed [23:0] noise_mean;
  logic        [23:0] noise_deviation;
  logic signed [23:0] ratio;
  logic signed [15:0] ratio_db;
  logic        [1:0]  status;
  logic               result_valid;
  logic               result_ready;

  masked_snr_estimator u_dut (
    .clk(clk), .rst(rst), .sample(sample), .is_signal(is_signal), .last(last),
    .voxel_valid(voxel_valid), .voxel_ready(voxel_ready),
    .signal_mean(signal_mean), .noise_mean(noise_mean),
    .noise_deviation(noise_deviation), .ratio(ratio), .ratio_db(ratio_db),
    .status(status), .result_valid(result_valid), .result_ready(result_ready)
  );

  // Volume accumulators of the predictor.
  longint          sig_sum, noi_sum;
  longint unsigned noi_sq;
  int unsigned     sig_cnt, noi_cnt;

  snr_result_t pending_results[$];
  int          tx_idle, rx_idle, phase;
  int          fail_cnt;
  int          quiet_cycles;
  bit          stim_done;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Round num*256/den to nearest, ties away from zero, clamp to 24 bits signed.
  function automatic longint scale_div(longint num, longint unsigned den);
    bit              neg;
    longint unsigned mag, q;
    neg = num < 0;
    mag = neg ? longint'(-num) : num;
    q = ((mag << 8) + den / 2) / den;
    if (neg) return (q > 64'd8388608) ? -64'sd8388608 : -longint'(q);
    return (q > 64'd8388607) ? 64'sd8388607 : longint'(q);
  endfunction

  function automatic longint unsigned root_round(longint unsigned q);
    longint unsigned r, b, x;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    x = q;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (q - r * r > r) r++;
    return r;
  endfunction

  // 20*log10(ratio/256) in Q8: log2 from the leading one plus squaring for the fraction.
  function automatic longint ratio_in_db(longint rt);
    longint unsigned r, x, fr;
    int              e;
    longint          lq, prod, q;
    r = rt;
    fr = 0;
    e = 0;
    while (e < 63 && (r >> (e + 1)) != 0) e++;
    x = r << (30 - e);
    for (int i = 15; i >= 0; i--) begin
      x = (x * x) >> 30;
      if (x >= 64'h8000_0000) begin
        x >>= 1;
        fr |= 64'd1 << i;
      end
    end
    lq = (longint'(e) - 8) * 65536 + longint'(fr);
    prod = lq * longint'(msnr_pkg::DB_PER_OCTAVE) + (64'sd1 << 23);
    q = prod >>> 24;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  function automatic void clear_volume();
    sig_sum = 0;
    noi_sum = 0;
    noi_sq  = 0;
    sig_cnt = 0;
    noi_cnt = 0;
  endfunction

  // Fold one voxel into the volume; on last, form the result and clear.
  function automatic bit add_voxel(logic signed [15:0] s, logic sig, logic lst,
                                   output snr_result_t res);
    longint            sm, nm, rt, db;
    longint unsigned   dv, amag, q64;
    bit [127:0]        a, b, num, qq;
    msnr_pkg::status_t st;
    if (sig) begin
      if (sig_cnt < COUNT_MAX) begin
        sig_sum += s;
        sig_cnt++;
      end
    end else if (noi_cnt < COUNT_MAX) begin
      noi_sum += s;
      noi_sq  += longint'(s) * longint'(s);
      noi_cnt++;
    end
    res = NO_WANT;
    if (!lst) return 1'b0;
    sm = 0; nm = 0; rt = 0; db = 0; dv = 0;
    if (sig_cnt != 0) sm = scale_div(sig_sum, sig_cnt);
    if (noi_cnt != 0) nm = scale_div(noi_sum, noi_cnt);
    if (noi_cnt >= 2) begin
      amag = (noi_sum < 0) ? longint'(-noi_sum) : noi_sum;
      a = 128'(noi_sq) * 128'(noi_cnt);
      b = 128'(amag) * 128'(amag);
      num = (a < b) ? 128'd0 : a - b;
      num <<= 16;
      qq = num / (128'(noi_cnt) * 128'(noi_cnt - 1));
      q64 = (qq[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : qq[63:0];
      dv = root_round(q64);
      if (dv > 64'd16777215) dv = 64'd16777215;
    end
    if (sig_cnt == 0)      st = msnr_pkg::ST_NO_SIGNAL;
    else if (noi_cnt < 2)  st = msnr_pkg::ST_FEW_NOISE;
    else if (dv == 0)      st = msnr_pkg::ST_NONPOS;
    else begin
      rt = scale_div(sm, dv);
      if (rt <= 0) begin
        st = msnr_pkg::ST_NONPOS;
        db = -32768;
      end else begin
        st = msnr_pkg::ST_OK;
        db = ratio_in_db(rt);
      end
    end
    res = '{sm[23:0], nm[23:0], dv[23:0], rt[23:0], db[15:0], st};
    clear_volume();
    return 1'b1;
  endfunction

  // Offer one word, hold it until taken, then update the predictor.
  task automatic send_voxel(voxel_row_t row);
    snr_result_t res;
    while ($urandom_range(99) < tx_idle) begin
      voxel_valid <= 1'b0;
      @(posedge clk);
    end
    voxel_valid <= 1'b1;
    sample      <= row.s;
    is_signal   <= row.sig;
    last        <= row.lst;
    do @(posedge clk); while (!voxel_ready);
    if (add_voxel(row.s, row.sig, row.lst, res))
      pending_results.push_back(row.typed ? row.want : res);
  endtask

  // Signal voxels sit well above a small noise floor most of the time.
  function automatic logic signed [15:0] pick_sample(bit sig);
    case ($urandom_range(9))
      0:       return 16'($urandom);
      1:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      default: return sig ? 16'($urandom_range(30000))
                          : 16'($signed($urandom_range(1200)) - 600);
    endcase
  endfunction

  task automatic send_random_volume();
    voxel_row_t row;
    int         len;
    bit         tidy;
    tidy = $urandom_range(9) != 0;
    len  = tidy ? $urandom_range(3, 12) : $urandom_range(1, 4);
    for (int i = 0; i < len; i++) begin
      row.sig   = tidy ? (i == 0 || (i > 2 && $urandom_range(2) == 0)) : $urandom_range(1);
      row.s     = pick_sample(row.sig);
      row.lst   = (i == len - 1);
      row.typed = 1'b0;
      row.want  = NO_WANT;
      send_voxel(row);
    end
  endtask

  // Stimulus: reset, directed table, three random phases; the drain block takes over after.
  initial begin
    voxel_row_t plan[$];
    int         sent;
    rst          = 1'b1;
    voxel_valid  = 1'b0;
    sample       = '0;
    is_signal    = 1'b0;
    last         = 1'b0;
    stim_done    = 1'b0;
    fail_cnt     = 0;
    phase        = 0;
    tx_idle      = 27;
    rx_idle      = 52;
    clear_volume();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single voxel volumes: the mean alone, status settles from the counts
    plan.push_back('{16'sd100, 1'b1, 1'b1, 1'b1,
                     '{24'sd25600, 24'sd0, 24'd0, 24'sd0, 16'sd0,
                       msnr_pkg::ST_FEW_NOISE}});
    plan.push_back('{16'sh8000, 1'b0, 1'b1, 1'b1,
                     '{24'sd0, -24'sd8388608, 24'd0, 24'sd0, 16'sd0,
                       msnr_pkg::ST_NO_SIGNAL}});
    plan.push_back('{16'sh7FFF, 1'b1, 1'b1, 1'b1,
                     '{24'sd8388352, 24'sd0, 24'd0, 24'sd0, 16'sd0,
                       msnr_pkg::ST_FEW_NOISE}});
    // one noise voxel only: still too few for a deviation
    plan.push_back('{16'sd5, 1'b1, 1'b0, 1'b0, NO_WANT});
    plan.push_back('{16'sd9, 1'b0, 1'b1, 1'b1,
                     '{24'sd1280, 24'sd2304, 24'd0, 24'sd0, 16'sd0,
                       msnr_pkg::ST_FEW_NOISE}});
    // extremes in both regions
    plan.push_back('{16'sh7FFF, 1'b1, 1'b0, 1'b0, NO_WANT});
    plan.push_back('{16'sh8000, 1'b0, 1'b0, 1'b0, NO_WANT});
    plan.push_back('{16'sh7FFF, 1'b0, 1'b1, 1'b0, NO_WANT});
    // flat noise: zero deviation
    plan.push_back('{16'sd5, 1'b1, 1'b0, 1'b0, NO_WANT});
    plan.push_back('{16'sd7, 1'b0, 1'b0, 1'b0, NO_WANT});
    plan.push_back('{16'sd7, 1'b0, 1'b1, 1'b0, NO_WANT});
    // negative signal mean: nonpositive ratio
    plan.push_back('{-16'sd1000, 1'b1, 1'b0, 1'b0, NO_WANT});
    plan.push_back('{16'sd0, 1'b0, 1'b0, 1'b0, NO_WANT});
    plan.push_back('{16'sd10, 1'b0, 1'b1, 1'b0, NO_WANT});
    // strong signal over small noise
    plan.push_back('{16'sd20000, 1'b1, 1'b0, 1'b0, NO_WANT});
    plan.push_back('{16'sd100, 1'b0, 1'b0, 1'b0, NO_WANT});
    plan.push_back('{-16'sd100, 1'b0, 1'b0, 1'b0, NO_WANT});
    plan.push_back('{16'sd50, 1'b0, 1'b1, 1'b0, NO_WANT});
    // weak signal under wide noise: negative dB
    plan.push_back('{16'sd1, 1'b1, 1'b0, 1'b0, NO_WANT});
    plan.push_back('{16'sd30000, 1'b0, 1'b0, 1'b0, NO_WANT});
    plan.push_back('{-16'sd30000, 1'b0, 1'b1, 1'b0, NO_WANT});
    foreach (plan[i]) send_voxel(plan[i]);

    for (int p = 0; p < 3; p++) begin
      phase   = p;
      tx_idle = (p == 0) ? 27 : (p == 1) ? 52 : 0;
      rx_idle = (p == 0) ? 52 : (p == 1) ? 27 : 0;
      sent = 0;
      while (sent < 135) begin
        send_random_volume();
        sent += 7;
      end
    end
    voxel_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: check each taken result, drive ready, and watch for a hang.
  initial begin
    snr_result_t want;
    int          hold_left;
    bit          held;
    result_ready = 1'b0;
    quiet_cycles = 0;
    hold_left    = 0;
    held         = 1'b0;
    forever begin
      @(posedge clk);
      quiet_cycles++;
      if (voxel_valid && voxel_ready) quiet_cycles = 0;
      if (!rst && result_valid && result_ready) begin
        quiet_cycles = 0;
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected");
          fail_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (signal_mean !== want.smean) begin
            $error("signal_mean: expected %0d, got %0d", want.smean, signal_mean);
            fail_cnt++;
          end
          if (noise_mean !== want.nmean) begin
            $error("noise_mean: expected %0d, got %0d", want.nmean, noise_mean);
            fail_cnt++;
          end
          if (noise_deviation !== want.dev) begin
            $error("noise_deviation: expected %0d, got %0d", want.dev, noise_deviation);
            fail_cnt++;
          end
          if (ratio !== want.ratio) begin
            $error("ratio: expected %0d, got %0d", want.ratio, ratio);
            fail_cnt++;
          end
          if (ratio_db !== want.db) begin
            $error("ratio_db: expected %0d, got %0d", want.db, ratio_db);
            fail_cnt++;
          end
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            fail_cnt++;
          end
        end
      end
      if (quiet_cycles >= WATCH_MAX) begin
        $display("tb_top failed");
        $finish;
      end
      // In the last phase, starve the output once so the queue fills and
      // the input side has to stall.
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (phase == 2 && !held) begin
        held      = 1'b1;
        hold_left = HOLD_LEN;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  // Drain: wait for every expected result, give the back end time, then report.
  initial begin
    wait (stim_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== masked_snr_estimator.f =====
+incdir+sv
sv/msnr_pkg.sv
sv/msnr_queue.sv
sv/msnr_div.sv
sv/msnr_front.sv
sv/msnr_back.sv
sv/masked_snr_estimator.sv
verif/tb_top.sv
